// File: design/swt_pkg.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer package
// Character codes, lexer state and result types shared by the tokenizer.
// ----------------------------------------------------------------------------
package swt_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_WORD   = 3'b010,
		MODE_QUOTED = 3'b100
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  quote_dq;
		logic  escape;
	} lex_state_t;

	typedef struct packed {
		logic       emit;
		logic       tend;
		logic       line_end;
		logic [7:0] data;
	} lex_result_t;

	localparam lex_state_t LEX_STATE_RESET = '{mode: MODE_IDLE, quote_dq: 1'b0, escape: 1'b0};

endpackage

// File: design/swt_lexer.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer lexer step
// Next-state and result logic for one byte of the command line.
// ----------------------------------------------------------------------------
module swt_lexer (
	input  swt_pkg::lex_state_t  cur,
	input  logic [7:0]           data,
	input  logic                 last,
	output swt_pkg::lex_state_t  nxt,
	output swt_pkg::lex_result_t res,
	output logic                 has_result
);

	logic is_sep;
	logic is_quote;
	logic is_bslash;
	logic kind_dq;
	logic emit;
	logic tend;
	logic opened;

	assign is_sep    = data inside {swt_pkg::CH_SPACE, swt_pkg::CH_TAB};
	assign is_quote  = data inside {swt_pkg::CH_SQUOTE, swt_pkg::CH_DQUOTE};
	assign is_bslash = (data == swt_pkg::CH_BSLASH);
	assign kind_dq   = (data == swt_pkg::CH_DQUOTE);

	always_comb begin
		nxt    = cur;
		emit   = 1'b0;
		tend   = 1'b0;
		opened = 1'b0;
		case (cur.mode)
			swt_pkg::MODE_WORD: begin
				if (is_sep) begin
					tend       = 1'b1;
					nxt.mode   = swt_pkg::MODE_IDLE;
					nxt.escape = 1'b0;
				end else if (is_quote) begin
					if (cur.escape) begin
						emit       = 1'b1;
						nxt.escape = 1'b0;
					end else begin
						tend         = 1'b1;
						nxt.mode     = swt_pkg::MODE_QUOTED;
						nxt.quote_dq = kind_dq;
						opened       = 1'b1;
					end
				end else if (is_bslash) begin
					nxt.escape = 1'b1;
				end else begin
					emit       = 1'b1;
					nxt.escape = 1'b0;
				end
			end
			swt_pkg::MODE_QUOTED: begin
				if (is_quote) begin
					if (cur.escape) begin
						emit       = 1'b1;
						nxt.escape = 1'b0;
					end else if (kind_dq == cur.quote_dq) begin
						tend     = 1'b1;
						nxt.mode = swt_pkg::MODE_IDLE;
					end
				end else if (is_bslash) begin
					nxt.escape = 1'b1;
				end else begin
					emit       = 1'b1;
					nxt.escape = 1'b0;
				end
			end
			default: begin
				nxt.mode   = swt_pkg::MODE_IDLE;
				nxt.escape = 1'b0;
				if (is_sep) begin
					nxt.mode = swt_pkg::MODE_IDLE;
				end else if (is_quote) begin
					nxt.mode     = swt_pkg::MODE_QUOTED;
					nxt.quote_dq = kind_dq;
				end else if (is_bslash) begin
					nxt.mode   = swt_pkg::MODE_WORD;
					nxt.escape = 1'b1;
				end else begin
					nxt.mode = swt_pkg::MODE_WORD;
					emit     = 1'b1;
				end
			end
		endcase
		if (last) begin
			if ((nxt.mode != swt_pkg::MODE_IDLE) && !opened) begin
				tend = 1'b1;
			end
			nxt = swt_pkg::LEX_STATE_RESET;
		end
	end

	assign res.emit     = emit;
	assign res.tend     = tend;
	assign res.line_end = last;
	assign res.data     = emit ? data : 8'h00;
	assign has_result   = emit | tend | last;

endmodule

// File: design/shell_word_tokenizer.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer
// Splits a command line, one byte per beat, into words with end marks.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the result side does not stall,
// and gives one result beat per byte that carries a word character, closes
// a word or ends the line; other bytes give no beat. A byte is registered on
// entry, passes through the lexer and its result is registered. The lexer
// state register updates with each byte that advances. A stall on the result
// side holds the result register and then the input register.
module shell_word_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       line_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       token_end,
	output logic       line_end
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	swt_pkg::lex_state_t  state_q;
	swt_pkg::lex_state_t  state_nxt;
	swt_pkg::lex_result_t res;
	swt_pkg::lex_result_t res_s2;
	logic                 has_result;
	logic                 valid_s2;
	logic                 advance;

	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	swt_lexer u_lexer (
		.cur        (state_q),
		.data       (byte_s1),
		.last       (last_s1),
		.nxt        (state_nxt),
		.res        (res),
		.has_result (has_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= swt_pkg::LEX_STATE_RESET;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= has_result;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= line_last;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign out_byte   = res_s2.data;
	assign byte_valid = res_s2.emit;
	assign token_end  = res_s2.tend;
	assign line_end   = res_s2.line_end;

endmodule

// File: design/swt_checker.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer checker
// Port-level assertions on the result beats of the tokenizer.
// ----------------------------------------------------------------------------
module swt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       token_end,
	input logic       line_end
);

	// Every result beat carries a character, a word close or a line end.
	a_beat_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_valid || token_end || line_end))
		else $error("result beat carries nothing");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (out_byte == 8'h00))
		else $error("out_byte nonzero without a word character");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_byte)
			&& $stable(byte_valid) && $stable(token_end) && $stable(line_end)))
		else $error("stalled result beat changed");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.token_end  (token_end),
	.line_end   (line_end)
);

// File: bench/shell_word_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer testbench
// Feeds command lines, directed and random, one byte per beat. A predictor
// lexes each accepted byte and queues the expected result beat. A monitor
// compares every accepted result beat with the oldest one queued. Both sides
// idle at random in several phases, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module shell_word_tokenizer_tb;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 240;
	localparam int REPORT_LIMIT = 50;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} line_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       line_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       token_end;
	logic       line_end;

	line_byte_t           pending_bytes[$];
	swt_pkg::lex_result_t expected_beats[$];
	line_byte_t           next_in;
	swt_pkg::lex_result_t oldest_beat;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;
	int fail_count = 0;

	swt_pkg::mode_t lx_mode = swt_pkg::MODE_IDLE;
	logic           lx_dq = 1'b0;
	logic           lx_escape = 1'b0;

	shell_word_tokenizer dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < REPORT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic tokenize_byte(input logic [7:0] b, input logic last);
		logic                 is_sep;
		logic                 is_quote;
		logic                 dq;
		logic                 emit;
		logic                 tend;
		logic                 opened_now;
		swt_pkg::lex_result_t r;
		is_sep = (b == swt_pkg::CH_SPACE) || (b == swt_pkg::CH_TAB);
		is_quote = (b == swt_pkg::CH_SQUOTE) || (b == swt_pkg::CH_DQUOTE);
		dq = (b == swt_pkg::CH_DQUOTE);
		emit = 1'b0;
		tend = 1'b0;
		opened_now = 1'b0;
		case (lx_mode)
			swt_pkg::MODE_WORD: begin
				if (is_sep) begin
					tend = 1'b1;
					lx_mode = swt_pkg::MODE_IDLE;
					lx_escape = 1'b0;
				end else if (is_quote) begin
					if (lx_escape) begin
						emit = 1'b1;
						lx_escape = 1'b0;
					end else begin
						tend = 1'b1;
						lx_mode = swt_pkg::MODE_QUOTED;
						lx_dq = dq;
						opened_now = 1'b1;
					end
				end else if (b == swt_pkg::CH_BSLASH) begin
					lx_escape = 1'b1;
				end else begin
					emit = 1'b1;
					lx_escape = 1'b0;
				end
			end
			swt_pkg::MODE_QUOTED: begin
				if (is_quote) begin
					if (lx_escape) begin
						emit = 1'b1;
						lx_escape = 1'b0;
					end else if (dq == lx_dq) begin
						tend = 1'b1;
						lx_mode = swt_pkg::MODE_IDLE;
					end
				end else if (b == swt_pkg::CH_BSLASH) begin
					lx_escape = 1'b1;
				end else begin
					emit = 1'b1;
					lx_escape = 1'b0;
				end
			end
			default: begin
				lx_mode = swt_pkg::MODE_IDLE;
				lx_escape = 1'b0;
				if (is_quote) begin
					lx_mode = swt_pkg::MODE_QUOTED;
					lx_dq = dq;
				end else if (b == swt_pkg::CH_BSLASH) begin
					lx_mode = swt_pkg::MODE_WORD;
					lx_escape = 1'b1;
				end else if (!is_sep) begin
					lx_mode = swt_pkg::MODE_WORD;
					emit = 1'b1;
				end
			end
		endcase
		// A quote that closes an unquoted word on the last byte opens a word
		// that is dropped, so only the unquoted word gets its end mark.
		if (last) begin
			if (lx_mode != swt_pkg::MODE_IDLE && !opened_now)
				tend = 1'b1;
			lx_mode = swt_pkg::MODE_IDLE;
			lx_dq = 1'b0;
			lx_escape = 1'b0;
		end
		if (emit || tend || last) begin
			r.emit = emit;
			r.tend = tend;
			r.line_end = last;
			r.data = emit ? b : 8'h00;
			expected_beats.push_back(r);
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		line_byte_t item;
		item.data = b;
		item.last = last;
		pending_bytes.push_back(item);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] word_char();
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(8'h7A, 8'h61));
	endfunction

	function automatic logic [7:0] sep_char();
		return $urandom_range(1) ? swt_pkg::CH_TAB : swt_pkg::CH_SPACE;
	endfunction

	function automatic logic [7:0] quote_char();
		return $urandom_range(1) ? swt_pkg::CH_DQUOTE : swt_pkg::CH_SQUOTE;
	endfunction

	task automatic queue_line();
		logic [7:0] line_q[$];
		logic [7:0] q;
		if ($urandom_range(5) == 0) begin
			repeat ($urandom_range(8, 1))
				line_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(6, 1)) begin
				case ($urandom_range(7))
					0, 1, 2: begin
						repeat ($urandom_range(4, 1))
							line_q.push_back(word_char());
					end
					3, 4: begin
						q = quote_char();
						line_q.push_back(q);
						repeat ($urandom_range(4)) begin
							case ($urandom_range(5))
								0: begin
									line_q.push_back(swt_pkg::CH_BSLASH);
									line_q.push_back(quote_char());
								end
								1: line_q.push_back((q == swt_pkg::CH_DQUOTE) ?
									swt_pkg::CH_SQUOTE : swt_pkg::CH_DQUOTE);
								2: line_q.push_back(sep_char());
								default: line_q.push_back(word_char());
							endcase
						end
						if ($urandom_range(7) != 0)
							line_q.push_back(q);
					end
					5: begin
						line_q.push_back(swt_pkg::CH_BSLASH);
						case ($urandom_range(3))
							0: line_q.push_back(quote_char());
							1: line_q.push_back(sep_char());
							2: line_q.push_back(swt_pkg::CH_BSLASH);
							default: line_q.push_back(word_char());
						endcase
					end
					default: begin
						repeat ($urandom_range(3, 1))
							line_q.push_back(sep_char());
					end
				endcase
			end
		end
		foreach (line_q[i])
			push_byte(line_q[i], i == line_q.size() - 1);
	endtask

	task automatic drain_input();
		while (pending_bytes.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			line_last <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				tokenize_byte(in_byte, line_last);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_in = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= next_in.data;
					line_last <= next_in.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					oldest_beat = expected_beats.pop_front();
					if (out_byte !== oldest_beat.data)
						report_mismatch($sformatf("out_byte %h, expected %h",
							out_byte, oldest_beat.data));
					if (byte_valid !== oldest_beat.emit)
						report_mismatch($sformatf("byte_valid %b, expected %b",
							byte_valid, oldest_beat.emit));
					if (token_end !== oldest_beat.tend)
						report_mismatch($sformatf("token_end %b, expected %b",
							token_end, oldest_beat.tend));
					if (line_end !== oldest_beat.line_end)
						report_mismatch($sformatf("line_end %b, expected %b",
							line_end, oldest_beat.line_end));
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("no beat accepted for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Escaped quotes in and out of quotes, a stray quote of the other kind,
		// a backslash before a separator, an empty quoted word, a quote that
		// ends a word on the last byte, and an unterminated quote at line end.
		push_text("x\\\"y 'p\"q\\'r'");
		push_text("\\ \"\"");
		push_text("a'");
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(swt_pkg::CH_TAB, 1'b0);
		push_byte(swt_pkg::CH_DQUOTE, 1'b1);
		drain_input();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_idle_pct = 13;
					recv_stall_pct = 13;
				end
			endcase
			while (pending_bytes.size() < PHASE_ITEMS)
				queue_line();
			drain_input();
		end

		// The output side holds off while the input keeps offering bytes.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending_bytes.size() < 80)
			queue_line();
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		drain_input();

		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
